### rtl/core/spiral_order_reader_top_defines.svh
// Assertion macros of the spiral order reader checker.
`ifndef SPIRAL_ORDER_READER_TOP_DEFINES_SVH
`define SPIRAL_ORDER_READER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SOR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spiral reader port check failed");

// Next-cycle implication, disabled while reset is high.
`define SOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiral reader port check failed");

`endif

### rtl/core/sor_pkg.sv
// Shared constants, types and helpers of the spiral order reader.
package sor_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int DATA_W     = 32;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LOAD_W     = ADDR_W + 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TOTAL_W    = 2 * DIM_W;
  // Width of the linear address sum row * cols + col.
  localparam int LIN_W      = ROW_W + DIM_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  // Launch of one spiral run.
  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [ADDR_W-1:0] last_index;
  } start_t;

  // Read request from the sequencer to the store.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Zero reads as one, anything above the maximum saturates.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

### rtl/core/sor_ram.sv
// Matrix store: one write port, one read port with registered data.
module sor_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [sor_pkg::ADDR_W-1:0]  waddr,
  input  logic [sor_pkg::DATA_W-1:0]  wdata,
  input  logic [sor_pkg::ADDR_W-1:0]  raddr,
  output logic [sor_pkg::DATA_W-1:0]  rdata
);

  logic [sor_pkg::DATA_W-1:0] mem [sor_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sor_spiral_gen.sv
// Spiral address sequencer: walks the boundaries and issues one read a cycle.
module sor_spiral_gen (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  sor_pkg::start_t  st,
  output logic             busy,
  output sor_pkg::rd_req_t req
);

  typedef enum logic [1:0] {PH_TOP, PH_RIGHT, PH_BOTTOM, PH_LEFT} phase_t;

  phase_t                          phase;
  logic                            active;
  logic [sor_pkg::ROW_W-1:0]       r, top, bot;
  logic [sor_pkg::COL_W-1:0]       c, lft, rgt;
  logic [sor_pkg::DIM_W-1:0]       cols_q;
  logic [sor_pkg::ADDR_W-1:0]      remaining;
  logic [sor_pkg::LIN_W-2:0]       prod;
  logic [sor_pkg::LIN_W-1:0]       lin;

  always_comb begin
    prod = (sor_pkg::LIN_W-1)'(r * cols_q);
    lin  = sor_pkg::LIN_W'(prod) + sor_pkg::LIN_W'(c);
  end

  assign busy       = active;
  assign req.valid  = active;
  assign req.last   = (remaining == '0);
  assign req.addr   = lin[sor_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= PH_TOP;
    end else if (!active) begin
      if (go) begin
        active    <= 1'b1;
        phase     <= PH_TOP;
        r         <= '0;
        c         <= '0;
        top       <= '0;
        lft       <= '0;
        bot       <= sor_pkg::ROW_W'(st.rows - sor_pkg::DIM_W'(1));
        rgt       <= sor_pkg::COL_W'(st.cols - sor_pkg::DIM_W'(1));
        cols_q    <= st.cols;
        remaining <= st.last_index;
      end
    end else begin
      if (remaining == '0) begin
        active <= 1'b0;
      end else begin
        remaining <= remaining - sor_pkg::ADDR_W'(1);
      end
      // At the end of a side, shrink that boundary and turn clockwise.
      case (phase)
        PH_TOP: begin
          if (c == rgt) begin
            top   <= top + sor_pkg::ROW_W'(1);
            r     <= r + sor_pkg::ROW_W'(1);
            phase <= PH_RIGHT;
          end else begin
            c <= c + sor_pkg::COL_W'(1);
          end
        end
        PH_RIGHT: begin
          if (r == bot) begin
            rgt   <= rgt - sor_pkg::COL_W'(1);
            c     <= c - sor_pkg::COL_W'(1);
            phase <= PH_BOTTOM;
          end else begin
            r <= r + sor_pkg::ROW_W'(1);
          end
        end
        PH_BOTTOM: begin
          if (c == lft) begin
            bot   <= bot - sor_pkg::ROW_W'(1);
            r     <= r - sor_pkg::ROW_W'(1);
            phase <= PH_LEFT;
          end else begin
            c <= c - sor_pkg::COL_W'(1);
          end
        end
        PH_LEFT: begin
          if (r == top) begin
            lft   <= lft + sor_pkg::COL_W'(1);
            c     <= c + sor_pkg::COL_W'(1);
            phase <= PH_TOP;
          end else begin
            r <= r - sor_pkg::ROW_W'(1);
          end
        end
        default: begin
          phase <= PH_TOP;
        end
      endcase
    end
  end

endmodule

### rtl/core/spiral_order_reader_top.sv
// Spiral order reader: loads a matrix row by row and replays it in spiral order.
//
// Usage. Elements enter on element with start; a beat is taken at a rising
// edge with start high and busy low, one element per cycle while busy is low.
// Each beat is written to the next slot of a 64-word store. row_count and
// col_count are set through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, as the block itself does not enforce it;
// zero reads as one and values above eight saturate at eight.
// The beat that completes R*C elements starts a run: busy rises on the next
// cycle and stays high while a sequencer issues one read per cycle to the
// store's single read port. Results appear on value with result_strobe, one
// per cycle and registered with the read data; final_res marks the last one.
// A run reads R*C elements, at most 64. Loading resumes as soon as busy falls.
// The receiver cannot stall: every strobe is a beat taken at that edge.
// Reset clears the load count and the run state and sets both dimensions to
// one; store contents stay undefined until written.
module spiral_order_reader_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sor_pkg::DATA_W-1:0] element,
  input  logic                              cfg_we,
  input  logic [sor_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sor_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              result_strobe,
  output logic signed [sor_pkg::DATA_W-1:0] value,
  output logic                              final_res
);

  logic [sor_pkg::DIM_W-1:0]   row_count, col_count;
  logic [sor_pkg::DIM_W-1:0]   rows, cols;
  logic [sor_pkg::TOTAL_W-1:0] total;
  logic [sor_pkg::LOAD_W-1:0]  loaded_count, loaded_next;
  logic [sor_pkg::ADDR_W-1:0]  slot;
  logic                        accept, go;
  sor_pkg::start_t             st;
  sor_pkg::rd_req_t            req;
  logic [sor_pkg::DATA_W-1:0]  rdata;

  always_comb begin
    rows        = sor_pkg::clamp_dim(row_count, sor_pkg::DIM_W'(sor_pkg::MAX_ROWS));
    cols        = sor_pkg::clamp_dim(col_count, sor_pkg::DIM_W'(sor_pkg::MAX_COLS));
    total       = sor_pkg::TOTAL_W'(rows * cols);
    slot        = loaded_count[sor_pkg::ADDR_W-1:0];
    loaded_next = sor_pkg::LOAD_W'(slot) + sor_pkg::LOAD_W'(1);
    accept      = start && !busy;
    go          = accept && (sor_pkg::TOTAL_W'(loaded_next) >= total);
    st.rows       = rows;
    st.cols       = cols;
    st.last_index = sor_pkg::ADDR_W'(total - sor_pkg::TOTAL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= sor_pkg::DIM_W'(1);
      col_count <= sor_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sor_pkg::CFG_ROW_COUNT: row_count <= cfg_data;
        sor_pkg::CFG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drop the count back to zero on the completing beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else if (accept) begin
      loaded_count <= go ? '0 : loaded_next;
    end
  end

  sor_ram u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (element),
    .raddr (req.addr),
    .rdata (rdata)
  );

  sor_spiral_gen u_gen (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .st   (st),
    .busy (busy),
    .req  (req)
  );

  // Strobe lines up with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      final_res     <= 1'b0;
    end else begin
      result_strobe <= req.valid;
      final_res     <= req.valid && req.last;
    end
  end

  assign value = rdata;

endmodule

### rtl/core/sor_checker.sv
// Port-level checks of the spiral order reader, bound to the top level.
`include "spiral_order_reader_top_defines.svh"

module sor_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_strobe,
  input logic final_res
);

  `SOR_ASSERT_IMPLY(a_final_on_beat, clk, rst, final_res, result_strobe)
  `SOR_ASSERT_IMPLY(a_beat_after_busy, clk, rst, result_strobe, $past(busy))
  `SOR_ASSERT_NEXT(a_gap_after_final, clk, rst, final_res, !result_strobe)
  `SOR_ASSERT_IMPLY(a_run_ends_final, clk, rst, !$past(rst) && $fell(busy),
                    result_strobe && final_res)

endmodule

bind spiral_order_reader_top sor_checker u_sor_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .result_strobe (result_strobe),
  .final_res     (final_res)
);
